[rtl/core/pse_pkg.sv]
// Shared types, constants and word conversion functions for the positional stack engine.
package pse_pkg;

   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int OCNT_W = 5;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   typedef enum logic [2:0] {
      BC_NONE,
      BC_PUSH,
      BC_UPDATE,
      BC_REMOVE,
      BC_INSERT
   } bc_kind_type;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] data_out;
      logic [OCNT_W-1:0]        count;
   } rsp_type;

   typedef struct packed {
      bc_kind_type kind;
      cnt_type     slot;
      cnt_type     count;
      word_type    word;
      logic        rd_en;
      cnt_type     rd_slot;
   } cell_ctrl_type;

   function automatic word_type to_word(input logic signed [DATA_W-1:0] d);
      logic signed [63:0] ext;
      ext = 64'(d);
      return ext[WORD_BITS-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] from_word(input word_type w);
      logic signed [WORD_BITS-1:0] sw;
      logic signed [63:0]          ext;
      sw  = w;
      ext = 64'(sw);
      return ext[DATA_W-1:0];
   endfunction

endpackage

[rtl/core/pse_cell.sv]
// One stack slot: holds a word and loads, shifts from a neighbor or holds each cycle.
module pse_cell (
   input  logic                   clock,
   input  pse_pkg::cell_ctrl_type ctrl,
   input  pse_pkg::cnt_type       cell_index,
   input  pse_pkg::word_type      lower_word,
   input  pse_pkg::word_type      upper_word,
   output pse_pkg::word_type      word_out,
   output pse_pkg::word_type      rd_word
);

   pse_pkg::word_type word_ff;
   pse_pkg::word_type word_in;

   always_comb begin
      word_in = word_ff;
      case (ctrl.kind)
         pse_pkg::BC_PUSH, pse_pkg::BC_UPDATE: begin
            if (cell_index == ctrl.slot) word_in = ctrl.word;
         end
         pse_pkg::BC_REMOVE: begin
            if (cell_index >= ctrl.slot &&
                (pse_pkg::CNT_W + 1)'(cell_index) + 1'b1 <
                (pse_pkg::CNT_W + 1)'(ctrl.count)) begin
               word_in = upper_word;
            end
         end
         pse_pkg::BC_INSERT: begin
            if (cell_index == ctrl.slot) begin
               word_in = ctrl.word;
            end else if (cell_index > ctrl.slot && cell_index <= ctrl.count) begin
               word_in = lower_word;
            end
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;
   assign rd_word  = (ctrl.rd_en && cell_index == ctrl.rd_slot) ? word_ff : '0;

endmodule

[rtl/core/pse_ctrl.sv]
// Command decode, range checks and fill count; broadcasts the slot operation to the cells.
module pse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  pse_pkg::req_type       req,
   output pse_pkg::cell_ctrl_type bc,
   output logic [pse_pkg::STAT_W-1:0] status,
   output pse_pkg::cnt_type       count_after
);

   pse_pkg::cnt_type count_ff;
   pse_pkg::cnt_type count_in;
   pse_pkg::cnt_type count_nxt;

   logic [pse_pkg::CMP_W-1:0] pos_x;
   logic [pse_pkg::CMP_W-1:0] cnt_x;
   logic [pse_pkg::CMP_W-1:0] pm1_x;
   pse_pkg::bc_kind_type      kind;

   assign pos_x = pse_pkg::CMP_W'(req.position);
   assign cnt_x = pse_pkg::CMP_W'(count_ff);
   assign pm1_x = pos_x - 1'b1;

   always_comb begin
      kind       = pse_pkg::BC_NONE;
      status     = pse_pkg::ST_OK;
      count_nxt  = count_ff;
      bc.slot    = pm1_x[pse_pkg::CNT_W-1:0];
      bc.rd_en   = 1'b0;
      bc.rd_slot = count_ff - 1'b1;
      case (req.command)
         pse_pkg::CMD_PUSH: begin
            bc.slot = count_ff;
            if (cnt_x >= pse_pkg::DEPTH_CMP) begin
               status = pse_pkg::ST_FULL;
            end else begin
               kind      = pse_pkg::BC_PUSH;
               count_nxt = count_ff + 1'b1;
            end
         end
         pse_pkg::CMD_POP, pse_pkg::CMD_PEEK: begin
            if (count_ff == '0) begin
               status = pse_pkg::ST_EMPTY;
            end else begin
               bc.rd_en = 1'b1;
               if (req.command == pse_pkg::CMD_POP) count_nxt = count_ff - 1'b1;
            end
         end
         pse_pkg::CMD_UPDATE: begin
            if (pos_x == '0 || pos_x > cnt_x) begin
               status = pse_pkg::ST_BADPOS;
            end else begin
               kind = pse_pkg::BC_UPDATE;
            end
         end
         pse_pkg::CMD_REMOVE: begin
            if (pos_x == '0 || pos_x > cnt_x) begin
               status = pse_pkg::ST_BADPOS;
            end else begin
               kind       = pse_pkg::BC_REMOVE;
               bc.rd_en   = 1'b1;
               bc.rd_slot = pm1_x[pse_pkg::CNT_W-1:0];
               count_nxt  = count_ff - 1'b1;
            end
         end
         pse_pkg::CMD_INSERT: begin
            if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
               status = pse_pkg::ST_BADPOS;
            end else if (cnt_x >= pse_pkg::DEPTH_CMP) begin
               status = pse_pkg::ST_FULL;
            end else begin
               kind      = pse_pkg::BC_INSERT;
               count_nxt = count_ff + 1'b1;
            end
         end
         default: begin
            kind = pse_pkg::BC_NONE;
         end
      endcase
      bc.kind  = fire ? kind : pse_pkg::BC_NONE;
      bc.count = count_ff;
      bc.word  = pse_pkg::to_word(req.data_in);
   end

   assign count_in    = fire ? count_nxt : count_ff;
   assign count_after = count_nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

[rtl/core/positional_stack_engine_top.sv]
// Top level: command decode, row of stack cells and registered response stage.
// Latency: a response is valid in the cycle after its request transfer.
// Throughput: one command per cycle while responses are taken; every cell of the
// row loads, shifts or holds in parallel in that single cycle.
// Reset clears the fill count and the response valid; stored words are not cleared.
module positional_stack_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pse_pkg::rsp_type rsp_data
);

   pse_pkg::cell_ctrl_type          bc;
   logic [pse_pkg::STAT_W-1:0]      status;
   pse_pkg::cnt_type                count_after;
   logic                            fire;

   pse_pkg::word_type cell_word [pse_pkg::DEPTH];
   pse_pkg::word_type cell_rd   [pse_pkg::DEPTH];
   pse_pkg::word_type rd_word;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   pse_pkg::rsp_type rsp_data_ff;
   pse_pkg::rsp_type rsp_data_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   pse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .req         (req_data),
      .bc          (bc),
      .status      (status),
      .count_after (count_after)
   );

   for (genvar gi = 0; gi < pse_pkg::DEPTH; gi++) begin : g_cell
      pse_pkg::word_type lower;
      pse_pkg::word_type upper;
      if (gi == 0) begin : g_bot
         assign lower = '0;
      end else begin : g_mid_lo
         assign lower = cell_word[gi-1];
      end
      if (gi == pse_pkg::DEPTH - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid_hi
         assign upper = cell_word[gi+1];
      end
      pse_cell u_cell (
         .clock      (clock),
         .ctrl       (bc),
         .cell_index (pse_pkg::CNT_W'(gi)),
         .lower_word (lower),
         .upper_word (upper),
         .word_out   (cell_word[gi]),
         .rd_word    (cell_rd[gi])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < pse_pkg::DEPTH; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end

   always_comb begin
      rsp_data_in.status   = status;
      rsp_data_in.data_out = bc.rd_en ? pse_pkg::from_word(rd_word) : '0;
      rsp_data_in.count    = pse_pkg::OCNT_W'(count_after);
   end

   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[dv/positional_stack_engine_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for positional_stack_engine_top: directed table and random commands.
module positional_stack_engine_top_tb;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1500;
   localparam int PLAN_ROWS    = 26;
   localparam int REPORT_MAX   = 10;

   localparam logic [pse_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [pse_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

   typedef struct packed {
      logic [pse_pkg::CMD_W-1:0]         command;
      logic [pse_pkg::POS_W-1:0]         position;
      logic signed [pse_pkg::DATA_W-1:0] data_in;
      logic [4:0]                        reps;
      logic                              typed;
      logic [pse_pkg::STAT_W-1:0]        want_status;
      logic signed [pse_pkg::DATA_W-1:0] want_data;
      logic [pse_pkg::OCNT_W-1:0]        want_count;
   } plan_row_type;

   plan_row_type plan [PLAN_ROWS] = '{
      '{pse_pkg::CMD_POP,    5'd0,  32'sd0,        5'd1,  1'b1, pse_pkg::ST_EMPTY,  32'sd0, 5'd0},
      '{pse_pkg::CMD_PEEK,   5'd0,  32'sd0,        5'd1,  1'b1, pse_pkg::ST_EMPTY,  32'sd0, 5'd0},
      '{pse_pkg::CMD_UPDATE, 5'd1,  32'sd7,        5'd1,  1'b1, pse_pkg::ST_BADPOS, 32'sd0, 5'd0},
      '{pse_pkg::CMD_REMOVE, 5'd0,  32'sd0,        5'd1,  1'b1, pse_pkg::ST_BADPOS, 32'sd0, 5'd0},
      '{pse_pkg::CMD_INSERT, 5'd2,  32'sd9,        5'd1,  1'b1, pse_pkg::ST_BADPOS, 32'sd0, 5'd0},
      '{pse_pkg::CMD_INSERT, 5'd0,  32'sd9,        5'd1,  1'b1, pse_pkg::ST_BADPOS, 32'sd0, 5'd0},
      '{pse_pkg::CMD_PUSH,   5'd0,  32'h7FFF_FFFF, 5'd1,  1'b1, pse_pkg::ST_OK,     32'sd0, 5'd1},
      '{pse_pkg::CMD_PUSH,   5'd31, 32'h8000_0000, 5'd1,  1'b1, pse_pkg::ST_OK,     32'sd0, 5'd2},
      '{pse_pkg::CMD_PEEK,   5'd0,  32'sd0,        5'd1,  1'b1, pse_pkg::ST_OK,
        32'h8000_0000, 5'd2},
      '{pse_pkg::CMD_INSERT, 5'd1,  32'sd5,        5'd1,  1'b0, pse_pkg::ST_OK,     32'sd0, 5'd0},
      '{pse_pkg::CMD_INSERT, 5'd4,  -32'sd1,       5'd1,  1'b0, pse_pkg::ST_OK,     32'sd0, 5'd0},
      '{pse_pkg::CMD_UPDATE, 5'd1,  32'sd0,        5'd1,  1'b0, pse_pkg::ST_OK,     32'sd0, 5'd0},
      '{pse_pkg::CMD_UPDATE, 5'd5,  32'sd3,        5'd1,  1'b1, pse_pkg::ST_BADPOS, 32'sd0, 5'd4},
      '{pse_pkg::CMD_REMOVE, 5'd2,  32'sd0,        5'd1,  1'b0, pse_pkg::ST_OK,     32'sd0, 5'd0},
      '{pse_pkg::CMD_REMOVE, 5'd3,  32'sd0,        5'd1,  1'b0, pse_pkg::ST_OK,     32'sd0, 5'd0},
      '{CMD_SPARE_A,         5'd1,  32'sd4,        5'd1,  1'b1, pse_pkg::ST_OK,     32'sd0, 5'd2},
      '{CMD_SPARE_B,         5'd31, -32'sd1,       5'd1,  1'b1, pse_pkg::ST_OK,     32'sd0, 5'd2},
      '{pse_pkg::CMD_PUSH,   5'd0,  32'h5555_5555, 5'd14, 1'b0, pse_pkg::ST_OK,     32'sd0, 5'd0},
      '{pse_pkg::CMD_PUSH,   5'd0,  32'sd1,        5'd1,  1'b1, pse_pkg::ST_FULL,   32'sd0, 5'd16},
      '{pse_pkg::CMD_INSERT, 5'd1,  32'sd1,        5'd1,  1'b1, pse_pkg::ST_FULL,   32'sd0, 5'd16},
      '{pse_pkg::CMD_INSERT, 5'd18, 32'sd1,        5'd1,  1'b1, pse_pkg::ST_BADPOS, 32'sd0, 5'd16},
      '{pse_pkg::CMD_INSERT, 5'd17, 32'sd1,        5'd1,  1'b1, pse_pkg::ST_FULL,   32'sd0, 5'd16},
      '{pse_pkg::CMD_REMOVE, 5'd31, 32'sd0,        5'd1,  1'b1, pse_pkg::ST_BADPOS, 32'sd0, 5'd16},
      '{pse_pkg::CMD_REMOVE, 5'd1,  32'sd0,        5'd1,  1'b0, pse_pkg::ST_OK,     32'sd0, 5'd0},
      '{pse_pkg::CMD_POP,    5'd0,  32'sd0,        5'd15, 1'b0, pse_pkg::ST_OK,     32'sd0, 5'd0},
      '{pse_pkg::CMD_POP,    5'd0,  32'sd0,        5'd1,  1'b1, pse_pkg::ST_EMPTY,  32'sd0, 5'd0}
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pse_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pse_pkg::rsp_type rsp_data;

   pse_pkg::word_type stack_mem [pse_pkg::DEPTH];
   int                stack_fill = 0;
   bit                grow = 1'b1;

   pse_pkg::rsp_type expected_rsps [$];
   bit               pinned_typed = 1'b0;
   pse_pkg::rsp_type pinned_want  = '0;
   int               mismatches   = 0;
   int               cycles       = 0;
   int               send_idle_pct = 20;
   int               stall_pct     = 20;
   int               stall_left    = 0;

   positional_stack_engine_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic pse_pkg::rsp_type stack_apply(input pse_pkg::req_type r);
      pse_pkg::rsp_type                     o;
      int                                   p;
      int                                   i;
      logic signed [pse_pkg::WORD_BITS-1:0] sw;
      o = '0;
      p = int'(r.position);
      case (r.command)
         pse_pkg::CMD_PUSH: begin
            if (stack_fill >= pse_pkg::DEPTH) begin
               o.status = pse_pkg::ST_FULL;
            end else begin
               stack_mem[stack_fill] = pse_pkg::word_type'(r.data_in);
               stack_fill++;
            end
         end
         pse_pkg::CMD_POP, pse_pkg::CMD_PEEK: begin
            if (stack_fill == 0) begin
               o.status = pse_pkg::ST_EMPTY;
            end else begin
               sw = stack_mem[stack_fill-1];
               o.data_out = pse_pkg::DATA_W'(sw);
               if (r.command == pse_pkg::CMD_POP) stack_fill--;
            end
         end
         pse_pkg::CMD_UPDATE: begin
            if (p < 1 || p > stack_fill) o.status = pse_pkg::ST_BADPOS;
            else stack_mem[p-1] = pse_pkg::word_type'(r.data_in);
         end
         pse_pkg::CMD_REMOVE: begin
            if (p < 1 || p > stack_fill) begin
               o.status = pse_pkg::ST_BADPOS;
            end else begin
               sw = stack_mem[p-1];
               o.data_out = pse_pkg::DATA_W'(sw);
               for (i = p - 1; i + 1 < stack_fill; i++) stack_mem[i] = stack_mem[i+1];
               stack_fill--;
            end
         end
         pse_pkg::CMD_INSERT: begin
            if (p < 1 || p > stack_fill + 1) begin
               o.status = pse_pkg::ST_BADPOS;
            end else if (stack_fill >= pse_pkg::DEPTH) begin
               o.status = pse_pkg::ST_FULL;
            end else begin
               for (i = stack_fill; i > p - 1; i--) stack_mem[i] = stack_mem[i-1];
               stack_mem[p-1] = pse_pkg::word_type'(r.data_in);
               stack_fill++;
            end
         end
         default: ;
      endcase
      o.count = pse_pkg::OCNT_W'(stack_fill);
      return o;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(15) == 0) return $urandom_range(40, 12);
      return $urandom_range(3, 1);
   endfunction

   function automatic pse_pkg::req_type random_command();
      pse_pkg::req_type r;
      int               roll;
      r.data_in = $urandom;
      case ($urandom_range(9))
         0: r.data_in = 32'h7FFF_FFFF;
         1: r.data_in = 32'h8000_0000;
         2: r.data_in = 32'sd0;
         3: r.data_in = -32'sd1;
         default: ;
      endcase
      r.position = 5'($urandom);
      roll = $urandom_range(99);
      if (roll < 2) begin
         r.command = ($urandom_range(1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
      end else if (roll < 9) begin
         r.command = 3'($urandom_range(5));
      end else begin
         roll = $urandom_range(99);
         if (grow) begin
            if (roll < 35) r.command = pse_pkg::CMD_PUSH;
            else if (roll < 55) r.command = pse_pkg::CMD_INSERT;
            else if (roll < 65) r.command = pse_pkg::CMD_POP;
            else if (roll < 75) r.command = pse_pkg::CMD_REMOVE;
            else if (roll < 85) r.command = pse_pkg::CMD_PEEK;
            else r.command = pse_pkg::CMD_UPDATE;
         end else begin
            if (roll < 10) r.command = pse_pkg::CMD_PUSH;
            else if (roll < 20) r.command = pse_pkg::CMD_INSERT;
            else if (roll < 50) r.command = pse_pkg::CMD_POP;
            else if (roll < 75) r.command = pse_pkg::CMD_REMOVE;
            else if (roll < 85) r.command = pse_pkg::CMD_PEEK;
            else r.command = pse_pkg::CMD_UPDATE;
         end
         roll = $urandom_range(19);
         if (roll == 0) begin
            r.position = '0;
         end else if (roll == 1) begin
            r.position = pse_pkg::POS_W'(stack_fill + 1);
         end else if (r.command == pse_pkg::CMD_INSERT) begin
            r.position = pse_pkg::POS_W'($urandom_range(stack_fill + 1, 1));
         end else if (stack_fill > 0) begin
            r.position = pse_pkg::POS_W'($urandom_range(stack_fill, 1));
         end
      end
      return r;
   endfunction

   task automatic send_command(input pse_pkg::req_type item, input bit typed,
                               input pse_pkg::rsp_type want);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data     = item;
      pinned_typed = typed;
      pinned_want  = want;
      req_valid    = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // predict on each request transfer, then check each response transfer
   always @(posedge clock) begin
      pse_pkg::rsp_type want;
      pse_pkg::rsp_type got;
      if (!reset && req_valid && req_ready) begin
         want = stack_apply(req_data);
         expected_rsps.push_back(pinned_typed ? pinned_want : want);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected response: status %0d data %h count %0d",
                        got.status, got.data_out, got.count);
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status || got.data_out !== want.data_out ||
                got.count !== want.count) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("response mismatch: status %0d/%0d data %h/%h count %0d/%0d",
                           want.status, got.status, want.data_out, got.data_out,
                           want.count, got.count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles % 300 == 0) begin
         case ($urandom_range(3))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            2: send_idle_pct = 30;
            default: send_idle_pct = 60;
         endcase
         case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 10;
            2: stall_pct = 30;
            default: stall_pct = 60;
         endcase
      end
      if (cycles == CYCLE_LIMIT) begin
         $display("[positional_stack_engine_top] ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if ($urandom_range(99) < stall_pct) stall_left = pick_gap();
      end
   end

   initial begin
      int               n;
      int               k;
      int               counted;
      pse_pkg::req_type item;
      pse_pkg::rsp_type want;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (n = 0; n < PLAN_ROWS; n++) begin
         for (k = 0; k < int'(plan[n].reps); k++) begin
            item.command  = plan[n].command;
            item.position = plan[n].position;
            item.data_in  = plan[n].data_in + k;
            want.status   = plan[n].want_status;
            want.data_out = plan[n].want_data;
            want.count    = plan[n].want_count;
            send_command(item, plan[n].typed, want);
         end
      end
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (stack_fill == pse_pkg::DEPTH) grow = 1'b0;
         else if (stack_fill == 0) grow = 1'b1;
         else if ($urandom_range(39) == 0) grow = !grow;
         item = random_command();
         send_command(item, 1'b0, '0);
         if (item.command <= pse_pkg::CMD_INSERT) counted++;
      end
      req_valid = 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("[positional_stack_engine_top] OK");
      end else begin
         $display("[positional_stack_engine_top] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/pse_pkg.sv
rtl/core/pse_cell.sv
rtl/core/pse_ctrl.sv
rtl/core/positional_stack_engine_top.sv
dv/positional_stack_engine_top_tb.sv
